[rtl/tpvo_pkg.sv]
`default_nettype none
package tpvo_pkg;

  localparam int unsigned CoordWidthDef = 16;
  localparam int unsigned HitWidth      = 3;
  localparam int unsigned PipeDepth     = 5;

  localparam logic [HitWidth-1:0] HIT_NONE     = 3'd0;
  localparam logic [HitWidth-1:0] HIT_SECOND_A = 3'd1;
  localparam logic [HitWidth-1:0] HIT_SECOND_B = 3'd2;
  localparam logic [HitWidth-1:0] HIT_SECOND_C = 3'd3;
  localparam logic [HitWidth-1:0] HIT_FIRST_A  = 3'd4;
  localparam logic [HitWidth-1:0] HIT_FIRST_B  = 3'd5;
  localparam logic [HitWidth-1:0] HIT_FIRST_C  = 3'd6;

  typedef struct packed {
    logic neg;
    logic zero;
  } sgn_t;

endpackage
`default_nettype wire

[rtl/tpvo_if.sv]
`default_nettype none
interface tpvo_in_if #(
  parameter int unsigned COORD_WIDTH = 16
);
  logic valid;
  logic ready;
  logic signed [COORD_WIDTH-1:0] first_ax;
  logic signed [COORD_WIDTH-1:0] first_ay;
  logic signed [COORD_WIDTH-1:0] first_bx;
  logic signed [COORD_WIDTH-1:0] first_by;
  logic signed [COORD_WIDTH-1:0] first_cx;
  logic signed [COORD_WIDTH-1:0] first_cy;
  logic signed [COORD_WIDTH-1:0] second_ax;
  logic signed [COORD_WIDTH-1:0] second_ay;
  logic signed [COORD_WIDTH-1:0] second_bx;
  logic signed [COORD_WIDTH-1:0] second_by;
  logic signed [COORD_WIDTH-1:0] second_cx;
  logic signed [COORD_WIDTH-1:0] second_cy;

  modport source (
    output valid, first_ax, first_ay, first_bx, first_by, first_cx, first_cy,
           second_ax, second_ay, second_bx, second_by, second_cx, second_cy,
    input  ready
  );
  modport sink (
    input  valid, first_ax, first_ay, first_bx, first_by, first_cx, first_cy,
           second_ax, second_ay, second_bx, second_by, second_cx, second_cy,
    output ready
  );
endinterface

interface tpvo_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] hit_code;

  modport source (output valid, hit_code, input ready);
  modport sink (input valid, hit_code, output ready);
endinterface
`default_nettype wire

[rtl/tpvo_cross_sign.sv]
`default_nettype none
module tpvo_cross_sign
  import tpvo_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = CoordWidthDef
) (
  input  wire                         clk_i,
  input  wire                         en_i,
  input  wire  signed [COORD_WIDTH:0] a_i,
  input  wire  signed [COORD_WIDTH:0] b_i,
  input  wire  signed [COORD_WIDTH:0] c_i,
  input  wire  signed [COORD_WIDTH:0] d_i,
  output sgn_t                        sgn_o
);
  // sign of a*b - c*d, products exact
  localparam int unsigned PW = 2 * COORD_WIDTH + 2;

  logic signed [PW-1:0] p_d, p_q, q_d, q_q;
  sgn_t                 sgn_d, sgn_q;

  assign p_d = PW'(a_i) * PW'(b_i);
  assign q_d = PW'(c_i) * PW'(d_i);

  always_comb begin
    sgn_d.neg  = p_q < q_q;
    sgn_d.zero = p_q == q_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q   <= p_d;
      q_q   <= q_d;
      sgn_q <= sgn_d;
    end
  end

  assign sgn_o = sgn_q;
endmodule
`default_nettype wire

[rtl/tpvo_tri_test.sv]
`default_nettype none
module tpvo_tri_test
  import tpvo_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = CoordWidthDef
) (
  input  wire                           clk_i,
  input  wire                           en_i,
  input  wire  signed [COORD_WIDTH-1:0] tv_i [6],
  input  wire  signed [COORD_WIDTH-1:0] pt_i [6],
  output logic        [2:0]             inside_o
);
  localparam int unsigned DW = COORD_WIDTH + 1;

  logic signed [DW-1:0] e21x_q, e21y_q, e31x_q, e31y_q, e32x_q, e32y_q;
  logic signed [DW-1:0] dx1_q [3];
  logic signed [DW-1:0] dy1_q [3];
  logic signed [DW-1:0] dx2_q [3];
  logic signed [DW-1:0] dy2_q [3];
  sgn_t                 area_sgn;
  sgn_t                 s1 [3];
  sgn_t                 s2 [3];
  sgn_t                 s3 [3];
  logic [2:0]           inside_d, inside_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e21x_q <= DW'(tv_i[2]) - DW'(tv_i[0]);
      e21y_q <= DW'(tv_i[3]) - DW'(tv_i[1]);
      e31x_q <= DW'(tv_i[4]) - DW'(tv_i[0]);
      e31y_q <= DW'(tv_i[5]) - DW'(tv_i[1]);
      e32x_q <= DW'(tv_i[4]) - DW'(tv_i[2]);
      e32y_q <= DW'(tv_i[5]) - DW'(tv_i[3]);
      for (int k = 0; k < 3; k++) begin
        dx1_q[k] <= DW'(pt_i[2*k])   - DW'(tv_i[0]);
        dy1_q[k] <= DW'(pt_i[2*k+1]) - DW'(tv_i[1]);
        dx2_q[k] <= DW'(pt_i[2*k])   - DW'(tv_i[2]);
        dy2_q[k] <= DW'(pt_i[2*k+1]) - DW'(tv_i[3]);
      end
    end
  end

  tpvo_cross_sign #(.COORD_WIDTH(COORD_WIDTH)) u_area (
    .clk_i, .en_i,
    .a_i(e21x_q), .b_i(e31y_q), .c_i(e31x_q), .d_i(e21y_q), .sgn_o(area_sgn)
  );

  for (genvar k = 0; k < 3; k++) begin : g_pt
    tpvo_cross_sign #(.COORD_WIDTH(COORD_WIDTH)) u_c1 (
      .clk_i, .en_i,
      .a_i(e31y_q), .b_i(dx1_q[k]), .c_i(e31x_q), .d_i(dy1_q[k]), .sgn_o(s1[k])
    );
    tpvo_cross_sign #(.COORD_WIDTH(COORD_WIDTH)) u_c2 (
      .clk_i, .en_i,
      .a_i(e21x_q), .b_i(dy1_q[k]), .c_i(e21y_q), .d_i(dx1_q[k]), .sgn_o(s2[k])
    );
    tpvo_cross_sign #(.COORD_WIDTH(COORD_WIDTH)) u_c3 (
      .clk_i, .en_i,
      .a_i(e32x_q), .b_i(dy2_q[k]), .c_i(e32y_q), .d_i(dx2_q[k]), .sgn_o(s3[k])
    );
  end

  // strictly inside: all edge signs match a nonzero area sign
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      inside_d[k] = !area_sgn.zero && (s1[k] == area_sgn) && (s2[k] == area_sgn)
                    && (s3[k] == area_sgn);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      inside_q <= inside_d;
    end
  end

  assign inside_o = inside_q;
endmodule
`default_nettype wire

[rtl/triangle_pair_vertex_overlap.sv]
`default_nettype none
// channel | dir | handshake           | payload
// in_i    | in  | in_i.valid/ready    | first_ax..first_cy, second_ax..second_cy
// out_o   | out | out_o.valid/ready   | hit_code
//
// One pair accepted per cycle while in_i.ready is high; result goes to out_o via
// five register stages (differences, products, cross signs, containment, hit code).
// rst_ni clears only the stage valid bits.
// A stalled output freezes every stage; in_i.ready is low only while
// out_o holds an item that is not taken.
module triangle_pair_vertex_overlap
  import tpvo_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = CoordWidthDef
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  tpvo_in_if.sink    in_i,
  tpvo_out_if.source out_o
);
  logic                          en;
  logic [PipeDepth-1:0]          v_q, v_d;
  logic signed [COORD_WIDTH-1:0] f_tv [6];
  logic signed [COORD_WIDTH-1:0] s_tv [6];
  logic [2:0]                    in_first, in_second;
  logic [HitWidth-1:0]           hit_d, hit_q;

  assign en         = out_o.ready || !v_q[PipeDepth-1];
  assign in_i.ready = en;

  assign f_tv[0] = in_i.first_ax;
  assign f_tv[1] = in_i.first_ay;
  assign f_tv[2] = in_i.first_bx;
  assign f_tv[3] = in_i.first_by;
  assign f_tv[4] = in_i.first_cx;
  assign f_tv[5] = in_i.first_cy;
  assign s_tv[0] = in_i.second_ax;
  assign s_tv[1] = in_i.second_ay;
  assign s_tv[2] = in_i.second_bx;
  assign s_tv[3] = in_i.second_by;
  assign s_tv[4] = in_i.second_cx;
  assign s_tv[5] = in_i.second_cy;

  tpvo_tri_test #(.COORD_WIDTH(COORD_WIDTH)) u_in_first (
    .clk_i, .en_i(en), .tv_i(f_tv), .pt_i(s_tv), .inside_o(in_first)
  );

  tpvo_tri_test #(.COORD_WIDTH(COORD_WIDTH)) u_in_second (
    .clk_i, .en_i(en), .tv_i(s_tv), .pt_i(f_tv), .inside_o(in_second)
  );

  always_comb begin
    if (in_first[0]) begin
      hit_d = HIT_SECOND_A;
    end else if (in_first[1]) begin
      hit_d = HIT_SECOND_B;
    end else if (in_first[2]) begin
      hit_d = HIT_SECOND_C;
    end else if (in_second[0]) begin
      hit_d = HIT_FIRST_A;
    end else if (in_second[1]) begin
      hit_d = HIT_FIRST_B;
    end else if (in_second[2]) begin
      hit_d = HIT_FIRST_C;
    end else begin
      hit_d = HIT_NONE;
    end
  end

  assign v_d = {v_q[PipeDepth-2:0], in_i.valid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q <= hit_d;
    end
  end

  assign out_o.valid    = v_q[PipeDepth-1];
  assign out_o.hit_code = hit_q;
endmodule
`default_nettype wire
